FILE: rtl/pbu_pkg.sv
// ---------------------------------------------------------------------------
// pbu_pkg
// Shared types and constants of the periodic boundary unit: request codes,
// register indexes, the control struct that travels down the pipeline and
// the image-index digit table.
// ---------------------------------------------------------------------------
package pbu_pkg;

  typedef enum logic [1:0] {
    OP_WRAP     = 2'd0,
    OP_FOLD     = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_SHIFT    = 2'd3
  } op_t;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd6;

  // Base-3 digit codes of the image index.
  localparam logic [1:0] DIG_PLUS  = 2'd1;
  localparam logic [1:0] DIG_MINUS = 2'd2;

  // Digits {z, y, x} for every 5-bit image index; codes past 26 repeat from code 0.
  localparam logic [5:0] DIGIT_TAB [32] = '{
    6'h00, 6'h01, 6'h02, 6'h04, 6'h05, 6'h06, 6'h08, 6'h09, 6'h0A,
    6'h10, 6'h11, 6'h12, 6'h14, 6'h15, 6'h16, 6'h18, 6'h19, 6'h1A,
    6'h20, 6'h21, 6'h22, 6'h24, 6'h25, 6'h26, 6'h28, 6'h29, 6'h2A,
    6'h00, 6'h01, 6'h02, 6'h04, 6'h05
  };

  typedef struct packed {
    logic       vld;
    op_t        op;
    logic       fold;    // remainder is taken by 2*size (minimum image)
    logic [5:0] digits;
  } ctl_t;

endpackage

FILE: rtl/pbu_if.sv
// ---------------------------------------------------------------------------
// pbu_if
// Request and result channels of the periodic boundary unit, each with
// valid, ready and its payload.
// ---------------------------------------------------------------------------
interface pbu_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic signed [W-1:0] pos_x;
  logic signed [W-1:0] pos_y;
  logic signed [W-1:0] pos_z;
  logic signed [W-1:0] ctr_x;
  logic signed [W-1:0] ctr_y;
  logic signed [W-1:0] ctr_z;
  logic [W-2:0]        half_side;
  logic [4:0]          image_index;

  modport source (output valid, req_type, pos_x, pos_y, pos_z, ctr_x, ctr_y, ctr_z,
                  half_side, image_index, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, pos_z, ctr_x, ctr_y, ctr_z,
                  half_side, image_index, output ready);
endinterface

interface pbu_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] res_x;
  logic signed [W-1:0] res_y;
  logic signed [W-1:0] res_z;
  logic                inside_res;

  modport source (output valid, res_x, res_y, res_z, inside_res, input ready);
  modport sink   (input valid, res_x, res_y, res_z, inside_res, output ready);
endinterface

FILE: rtl/periodic_boundary_unit_top.sv
// ---------------------------------------------------------------------------
// periodic_boundary_unit_top
// Periodic box unit: wrap, minimum-image fold, cube containment and
// neighbor image shift on Q16.16 coordinates.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  in_ch    | in        | valid/ready         | req_type, pos, ctr, half_side, image_index
//  out_ch   | out       | valid/ready         | res_x, res_y, res_z, inside_res
//  cfg_*    | in        | cfg_we, no ready    | cfg_index, cfg_wdata
//
//  One item enters per cycle while the pipeline is not held. There are
//  COORD_WIDTH + 7 register stages, most of them in the remainder pipeline
//  that resolves one dividend bit per stage.
//  Reset is synchronous and clears the valid bits and the configuration registers.
//  When the output register holds an item that is not taken, the whole
//  pipeline holds and in_ch.ready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module periodic_boundary_unit_top #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pbu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_WIDTH-1:0]          cfg_wdata,
  pbu_in_if.sink                          in_ch,
  pbu_out_if.source                       out_ch
);

  localparam int W = COORD_WIDTH;

  logic                en_r;
  logic signed [W-1:0] origin_r [3];
  logic [W-2:0]        size_r [3];

  logic                adv;
  logic signed [W-1:0] pos [3];
  logic signed [W-1:0] ctr [3];

  pbu_pkg::ctl_t b_ctl, d_ctl;
  logic [W-2:0]  b_he, d_he;
  logic [W+2:0]  b_mag [3];
  logic          b_neg [3], d_neg [3];
  logic [W:0]    b_v [3], d_v [3];
  logic [W-1:0]  d_rem [3];
  logic signed [W-1:0] res [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r     <= 1'b0;
      origin_r <= '{default: '0};
      size_r   <= '{default: '0};
    end else if (cfg_we) begin
      case (cfg_index)
        pbu_pkg::REG_ENABLE:   en_r        <= cfg_wdata[0];
        pbu_pkg::REG_ORIGIN_X: origin_r[0] <= cfg_wdata;
        pbu_pkg::REG_ORIGIN_Y: origin_r[1] <= cfg_wdata;
        pbu_pkg::REG_ORIGIN_Z: origin_r[2] <= cfg_wdata;
        pbu_pkg::REG_SIZE_X:   size_r[0]   <= cfg_wdata[W-2:0];
        pbu_pkg::REG_SIZE_Y:   size_r[1]   <= cfg_wdata[W-2:0];
        pbu_pkg::REG_SIZE_Z:   size_r[2]   <= cfg_wdata[W-2:0];
        default: ;
      endcase
    end
  end

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  assign pos[0] = in_ch.pos_x;
  assign pos[1] = in_ch.pos_y;
  assign pos[2] = in_ch.pos_z;
  assign ctr[0] = in_ch.ctr_x;
  assign ctr[1] = in_ch.ctr_y;
  assign ctr[2] = in_ch.ctr_z;

  pbu_prep #(.W(W)) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_vld      (in_ch.valid),
    .req_type    (in_ch.req_type),
    .pos         (pos),
    .ctr         (ctr),
    .half_side   (in_ch.half_side),
    .image_index (in_ch.image_index),
    .en          (en_r),
    .origin      (origin_r),
    .size        (size_r),
    .b_ctl       (b_ctl),
    .b_he        (b_he),
    .b_mag       (b_mag),
    .b_neg       (b_neg),
    .b_v         (b_v)
  );

  pbu_div #(.W(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .size  (size_r),
    .i_ctl (b_ctl),
    .i_he  (b_he),
    .i_mag (b_mag),
    .i_neg (b_neg),
    .i_v   (b_v),
    .o_ctl (d_ctl),
    .o_he  (d_he),
    .o_rem (d_rem),
    .o_neg (d_neg),
    .o_v   (d_v)
  );

  pbu_post #(.W(W)) u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .origin  (origin_r),
    .size    (size_r),
    .i_ctl   (d_ctl),
    .i_he    (d_he),
    .i_rem   (d_rem),
    .i_neg   (d_neg),
    .i_v     (d_v),
    .out_vld (out_ch.valid),
    .res     (res),
    .in_cube (out_ch.inside_res)
  );

  assign out_ch.res_x = res[0];
  assign out_ch.res_y = res[1];
  assign out_ch.res_z = res[2];

endmodule

FILE: rtl/pbu_prep.sv
// ---------------------------------------------------------------------------
// pbu_prep
// Front stages: forms the per-axis difference (or the bare position for
// fold), then the signed dividend and its magnitude for the remainder pipeline.
// ---------------------------------------------------------------------------
module pbu_prep #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [1:0]          req_type,
  input  logic signed [W-1:0] pos [3],
  input  logic signed [W-1:0] ctr [3],
  input  logic [W-2:0]        half_side,
  input  logic [4:0]          image_index,
  input  logic                en,
  input  logic signed [W-1:0] origin [3],
  input  logic [W-2:0]        size [3],
  output pbu_pkg::ctl_t       b_ctl,
  output logic [W-2:0]        b_he,
  output logic [W+2:0]        b_mag [3],
  output logic                b_neg [3],
  output logic [W:0]          b_v [3]
);

  pbu_pkg::ctl_t a_ctl_r, a_ctl_nxt;
  logic [W:0]    a_v_r [3];
  logic [W:0]    a_v_nxt [3];
  logic [W-2:0]  a_he_r;

  pbu_pkg::ctl_t b_ctl_r;
  logic [W+2:0]  b_mag_r [3];
  logic [W+2:0]  b_mag_nxt [3];
  logic          b_neg_r [3];
  logic          b_neg_nxt [3];
  logic [W:0]    b_v_r [3];
  logic [W-2:0]  b_he_r;

  always_comb begin
    a_ctl_nxt.vld    = in_vld;
    a_ctl_nxt.op     = pbu_pkg::op_t'(req_type);
    a_ctl_nxt.fold   = (a_ctl_nxt.op == pbu_pkg::OP_FOLD) ||
                       ((a_ctl_nxt.op == pbu_pkg::OP_CONTAINS) && en);
    a_ctl_nxt.digits = pbu_pkg::DIGIT_TAB[image_index];
    for (int i = 0; i < 3; i++) begin
      case (a_ctl_nxt.op)
        pbu_pkg::OP_WRAP:     a_v_nxt[i] = {pos[i][W-1], pos[i]} - {origin[i][W-1], origin[i]};
        pbu_pkg::OP_FOLD:     a_v_nxt[i] = {pos[i][W-1], pos[i]};
        pbu_pkg::OP_CONTAINS: a_v_nxt[i] = {pos[i][W-1], pos[i]} - {ctr[i][W-1], ctr[i]};
        default:              a_v_nxt[i] = '0;
      endcase
    end
  end

  // Folding uses (2v + size) mod 2*size; wrap uses v mod size.
  always_comb begin
    logic [W+2:0] vx;
    logic [W+2:0] n;
    for (int i = 0; i < 3; i++) begin
      vx = {{2{a_v_r[i][W]}}, a_v_r[i]};
      n  = a_ctl_r.fold ? ((vx << 1) + {4'b0000, size[i]}) : vx;
      b_neg_nxt[i] = n[W+2];
      b_mag_nxt[i] = n[W+2] ? (~n + 1'b1) : n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
    end else if (adv) begin
      a_ctl_r <= a_ctl_nxt;
      b_ctl_r <= a_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_v_r   <= a_v_nxt;
      a_he_r  <= half_side;
      b_mag_r <= b_mag_nxt;
      b_neg_r <= b_neg_nxt;
      b_v_r   <= a_v_r;
      b_he_r  <= a_he_r;
    end
  end

  assign b_ctl = b_ctl_r;
  assign b_he  = b_he_r;
  assign b_mag = b_mag_r;
  assign b_neg = b_neg_r;
  assign b_v   = b_v_r;

endmodule

FILE: rtl/pbu_div.sv
// ---------------------------------------------------------------------------
// pbu_div
// Pipelined restoring remainder: one dividend bit per stage on all three
// axes, W+3 stages in all.
// ---------------------------------------------------------------------------
module pbu_div #(
  parameter int W = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic [W-2:0]  size [3],
  input  pbu_pkg::ctl_t i_ctl,
  input  logic [W-2:0]  i_he,
  input  logic [W+2:0]  i_mag [3],
  input  logic          i_neg [3],
  input  logic [W:0]    i_v [3],
  output pbu_pkg::ctl_t o_ctl,
  output logic [W-2:0]  o_he,
  output logic [W-1:0]  o_rem [3],
  output logic          o_neg [3],
  output logic [W:0]    o_v [3]
);

  localparam int NB = W + 3;

  pbu_pkg::ctl_t s_ctl_r [NB];
  logic [W-2:0]  s_he_r  [NB];
  logic [W-1:0]  s_rem_r [NB][3];
  logic [W+2:0]  s_mag_r [NB][3];
  logic          s_neg_r [NB][3];
  logic [W:0]    s_v_r   [NB][3];

  for (genvar j = 0; j < NB; j++) begin : g_stg
    localparam int B = NB - 1 - j;

    pbu_pkg::ctl_t c_in;
    logic [W-2:0]  he_in;
    logic [W-1:0]  r_in  [3];
    logic [W+2:0]  m_in  [3];
    logic          n_in  [3];
    logic [W:0]    v_in  [3];
    logic [W-1:0]  r_nxt [3];

    if (j == 0) begin : g_first
      assign c_in  = i_ctl;
      assign he_in = i_he;
      for (genvar a = 0; a < 3; a++) begin : g_ax
        assign r_in[a] = '0;
        assign m_in[a] = i_mag[a];
        assign n_in[a] = i_neg[a];
        assign v_in[a] = i_v[a];
      end
    end else begin : g_next
      assign c_in  = s_ctl_r[j-1];
      assign he_in = s_he_r[j-1];
      for (genvar a = 0; a < 3; a++) begin : g_ax
        assign r_in[a] = s_rem_r[j-1][a];
        assign m_in[a] = s_mag_r[j-1][a];
        assign n_in[a] = s_neg_r[j-1][a];
        assign v_in[a] = s_v_r[j-1][a];
      end
    end

    always_comb begin
      logic [W-1:0] d;
      logic [W:0]   t;
      logic [W:0]   diff;
      for (int a = 0; a < 3; a++) begin
        d    = c_in.fold ? {size[a], 1'b0} : {1'b0, size[a]};
        t    = {r_in[a], m_in[a][B]};
        diff = t - {1'b0, d};
        r_nxt[a] = (t >= {1'b0, d}) ? diff[W-1:0] : t[W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_ctl_r[j] <= '0;
      end else if (adv) begin
        s_ctl_r[j] <= c_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_he_r[j]  <= he_in;
        s_rem_r[j] <= r_nxt;
        s_mag_r[j] <= m_in;
        s_neg_r[j] <= n_in;
        s_v_r[j]   <= v_in;
      end
    end
  end

  assign o_ctl = s_ctl_r[NB-1];
  assign o_he  = s_he_r[NB-1];
  assign o_rem = s_rem_r[NB-1];
  assign o_neg = s_neg_r[NB-1];
  assign o_v   = s_v_r[NB-1];

endmodule

FILE: rtl/pbu_post.sv
// ---------------------------------------------------------------------------
// pbu_post
// Back stages: turns the magnitude remainder into a floor modulo, then
// forms wrap, fold, containment and image shift results with saturation.
// The last stage is the output register.
// ---------------------------------------------------------------------------
module pbu_post #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic signed [W-1:0] origin [3],
  input  logic [W-2:0]        size [3],
  input  pbu_pkg::ctl_t       i_ctl,
  input  logic [W-2:0]        i_he,
  input  logic [W-1:0]        i_rem [3],
  input  logic                i_neg [3],
  input  logic [W:0]          i_v [3],
  output logic                out_vld,
  output logic signed [W-1:0] res [3],
  output logic                in_cube
);

  pbu_pkg::ctl_t c_ctl_r;
  logic [W-2:0]  c_he_r;
  logic [W-1:0]  c_m_r [3];
  logic [W-1:0]  c_m_nxt [3];
  logic [W:0]    c_v_r [3];

  logic                out_vld_r;
  logic signed [W-1:0] res_r [3];
  logic signed [W-1:0] res_nxt [3];
  logic                inside_r, inside_nxt;

  always_comb begin
    logic [W-1:0] d;
    for (int a = 0; a < 3; a++) begin
      d = i_ctl.fold ? {size[a], 1'b0} : {1'b0, size[a]};
      c_m_nxt[a] = (i_neg[a] && (i_rem[a] != '0)) ? (d - i_rem[a]) : i_rem[a];
    end
  end

  always_comb begin
    logic              zero;
    logic [W:0]        diff;
    logic signed [W:0] fv;
    logic signed [W:0] base;
    logic signed [W:0] dd;
    logic signed [W:0] he_s;
    logic signed [W+1:0] sum;
    logic              all_in;
    all_in = 1'b1;
    for (int a = 0; a < 3; a++) begin
      zero = (size[a] == '0);
      diff = {1'b0, c_m_r[a]} - {2'b00, size[a]};
      fv   = $signed({diff[W], diff[W:1]});
      he_s = $signed({2'b00, c_he_r});
      case (c_ctl_r.op)
        pbu_pkg::OP_WRAP: begin
          base = zero ? $signed(c_v_r[a]) : $signed({1'b0, c_m_r[a]});
          sum  = $signed({{2{origin[a][W-1]}}, origin[a]}) + $signed({base[W], base});
        end
        pbu_pkg::OP_FOLD: begin
          base = zero ? $signed(c_v_r[a]) : fv;
          sum  = $signed({base[W], base});
        end
        pbu_pkg::OP_SHIFT: begin
          base = '0;
          if (c_ctl_r.digits[2*a +: 2] == pbu_pkg::DIG_PLUS) begin
            sum = $signed({3'b000, size[a]});
          end else if (c_ctl_r.digits[2*a +: 2] == pbu_pkg::DIG_MINUS) begin
            sum = -$signed({3'b000, size[a]});
          end else begin
            sum = '0;
          end
        end
        default: begin
          base = '0;
          sum  = '0;
        end
      endcase
      // Containment works on the exact difference, folded only when enabled.
      dd = (c_ctl_r.fold && !zero) ? fv : $signed(c_v_r[a]);
      if (!((dd <= he_s) && (dd >= -he_s))) begin
        all_in = 1'b0;
      end
      if ((sum[W+1:W-1] == 3'b000) || (sum[W+1:W-1] == 3'b111)) begin
        res_nxt[a] = sum[W-1:0];
      end else if (sum[W+1]) begin
        res_nxt[a] = {1'b1, {(W-1){1'b0}}};
      end else begin
        res_nxt[a] = {1'b0, {(W-1){1'b1}}};
      end
    end
    inside_nxt = (c_ctl_r.op == pbu_pkg::OP_CONTAINS) && all_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ctl_r   <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      c_ctl_r   <= i_ctl;
      out_vld_r <= c_ctl_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_he_r   <= i_he;
      c_m_r    <= c_m_nxt;
      c_v_r    <= i_v;
      res_r    <= res_nxt;
      inside_r <= inside_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign res     = res_r;
  assign in_cube = inside_r;

endmodule

FILE: rtl/pbu_checker.sv
// ---------------------------------------------------------------------------
// pbu_checker
// Port-level checks of the periodic boundary unit, bound to the top level.
// ---------------------------------------------------------------------------
module pbu_checker #(
  parameter int W = 32
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] res_x,
  input logic [W-1:0] res_y,
  input logic [W-1:0] res_z,
  input logic         inside_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(res_x) && $stable(res_y) && $stable(res_z) &&
                                $stable(inside_res))
    else $error("stalled result item changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready although the output register is empty");

  a_inside_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && inside_res |-> (res_x == '0) && (res_y == '0) && (res_z == '0))
    else $error("containment item carries nonzero coordinates");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind periodic_boundary_unit_top pbu_checker #(.W(COORD_WIDTH)) u_pbu_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .res_x      (out_ch.res_x),
  .res_y      (out_ch.res_y),
  .res_z      (out_ch.res_z),
  .inside_res (out_ch.inside_res)
);
